[src/vtwp_pkg.sv]
// Shared types and constants for the value-to-word packer.
package vtwp_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned VW_W    = 6;
  localparam int unsigned VPT_W   = 9;
  localparam int unsigned WPT_W   = 5;
  localparam int unsigned HELD_W  = 5;
  localparam int unsigned VCMP_W  = 13;
  localparam int unsigned PAD_W   = 7;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_VALUE_WIDTH   = 2'd0;
  localparam logic [IDX_W-1:0] REG_VALUES_PER_TR = 2'd1;
  localparam logic [IDX_W-1:0] REG_WORDS_PER_TR  = 2'd2;

  localparam logic [VW_W-1:0]  VW_RESET  = 6'd8;
  localparam logic [VPT_W-1:0] VPT_RESET = 9'd1;
  localparam logic [WPT_W-1:0] WPT_RESET = 5'd1;

  typedef struct packed {
    logic [VW_W-1:0]  value_width;
    logic [VPT_W-1:0] values_per_transfer;
    logic [WPT_W-1:0] words_per_transfer;
  } cfg_t;

  // Words produced by one value: up to two data words, then zero pads.
  typedef struct packed {
    logic [WORD_W-1:0] w0;
    logic              w0_v;
    logic [WORD_W-1:0] w1;
    logic              w1_v;
    logic [PAD_W-1:0]  pad;
    logic              batch;
  } res_t;

endpackage

[src/value_to_word_transfer_packer_unit.sv]
// Top level of the value-to-word packer: input register, packer, result buffer.
// Packs value_width-bit values LSB first into 32-bit words. One value is taken
// per cycle while the result buffer can take it; it is registered, then packed
// combinationally into a result buffer holding at most two data words plus the
// zero pads that close a transfer. The buffer sends one word per cycle while
// the output is ready. A value yields 0..2 words, or up to words_per_transfer
// (capped at MaxWords) when zero pads fill out a transfer end, and the input
// stalls while the buffer holds words, until its last word is taken. From input
// accept to first word, a value passes the input register and the result buffer.
// tlast on the output marks the final word of a batch; tuser marks the last
// word caused by one value.
module value_to_word_transfer_packer_unit #(
  parameter int unsigned MaxWords  = 16,
  parameter int unsigned MaxValues = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vtwp_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [vtwp_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [vtwp_pkg::WORD_W-1:0]  s_axis_tdata,   // [31:0] value
  input  logic                         s_axis_tlast,   // batch_end
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [vtwp_pkg::WORD_W-1:0]  m_axis_tdata,   // [31:0] word
  output logic                         m_axis_tuser,   // [0] run_last
  output logic                         m_axis_tlast    // batch_last
);

  vtwp_pkg::cfg_t              cfg_q, cfg_d;
  vtwp_pkg::res_t              res;
  logic                        in_v_q, in_v_d;
  logic [vtwp_pkg::WORD_W-1:0] in_value_q;
  logic                        in_last_q;
  logic                        buf_free, adv, load, take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        vtwp_pkg::REG_VALUE_WIDTH:   cfg_d.value_width =
                                       cfg_data_i[vtwp_pkg::VW_W-1:0];
        vtwp_pkg::REG_VALUES_PER_TR: cfg_d.values_per_transfer =
                                       cfg_data_i[vtwp_pkg::VPT_W-1:0];
        vtwp_pkg::REG_WORDS_PER_TR:  cfg_d.words_per_transfer =
                                       cfg_data_i[vtwp_pkg::WPT_W-1:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.value_width         <= vtwp_pkg::VW_RESET;
      cfg_q.values_per_transfer <= vtwp_pkg::VPT_RESET;
      cfg_q.words_per_transfer  <= vtwp_pkg::WPT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign adv           = in_v_q && buf_free;
  assign s_axis_tready = !in_v_q || adv;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign load          = adv && (res.w0_v || res.w1_v || (res.pad != '0));

  always_comb begin
    in_v_d = in_v_q;
    if (take) begin
      in_v_d = 1'b1;
    end else if (adv) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_value_q <= s_axis_tdata;
      in_last_q  <= s_axis_tlast;
    end
  end

  vtwp_pack #(
    .MaxWords  (MaxWords),
    .MaxValues (MaxValues)
  ) u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .value_i     (in_value_q),
    .batch_end_i (in_last_q),
    .cfg_i       (cfg_q),
    .res_o       (res)
  );

  vtwp_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .res_i        (res),
    .free_o       (buf_free),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .word_o       (m_axis_tdata),
    .run_last_o   (m_axis_tuser),
    .batch_last_o (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_batch_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("batch_last without run_last");

  a_held_value_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !buf_free |=> in_v_q && $stable(in_value_q) && $stable(in_last_q))
    else $error("input register lost a pending value");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> buf_free && in_v_q)
    else $error("result buffer overwritten");

  a_load_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid)
    else $error("loaded result produced no word");
`endif

endmodule

[src/vtwp_pack.sv]
// Bit accumulator, transfer counters and per-value word generation.
module vtwp_pack #(
  parameter int unsigned MaxWords  = 16,
  parameter int unsigned MaxValues = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [vtwp_pkg::WORD_W-1:0] value_i,
  input  logic                       batch_end_i,
  input  vtwp_pkg::cfg_t             cfg_i,
  output vtwp_pkg::res_t             res_o
);

  logic [vtwp_pkg::WORD_W-1:0] acc_q, acc_d;
  logic [vtwp_pkg::HELD_W-1:0] held_q, held_d;
  logic [vtwp_pkg::VPT_W-1:0]  vit_q, vit_d;
  logic [vtwp_pkg::WPT_W-1:0]  wit_q, wit_d;

  logic [vtwp_pkg::VW_W-1:0]   w_eff;
  logic [vtwp_pkg::VCMP_W-1:0] vpt_eff;
  logic [vtwp_pkg::PAD_W-1:0]  wpt_eff;
  logic [vtwp_pkg::WORD_W-1:0] mask, v;
  logic [2*vtwp_pkg::WORD_W-1:0] sum;
  logic [vtwp_pkg::VW_W-1:0]   tot;
  logic                        full, end_t, close, flush;
  logic [vtwp_pkg::WORD_W-1:0] rest;
  logic [vtwp_pkg::VPT_W-1:0]  vit_n;
  logic [vtwp_pkg::WPT_W-1:0]  wit_a, wit_b;
  logic [vtwp_pkg::PAD_W-1:0]  wit_x;

  always_comb begin
    if (cfg_i.value_width == '0) begin
      w_eff = 6'd1;
    end else if (cfg_i.value_width > 6'd32) begin
      w_eff = 6'd32;
    end else begin
      w_eff = cfg_i.value_width;
    end

    if (cfg_i.values_per_transfer == '0) begin
      vpt_eff = vtwp_pkg::VCMP_W'(1);
    end else if (vtwp_pkg::VCMP_W'(cfg_i.values_per_transfer) > vtwp_pkg::VCMP_W'(MaxValues)) begin
      vpt_eff = vtwp_pkg::VCMP_W'(MaxValues);
    end else begin
      vpt_eff = vtwp_pkg::VCMP_W'(cfg_i.values_per_transfer);
    end

    if (cfg_i.words_per_transfer == '0) begin
      wpt_eff = vtwp_pkg::PAD_W'(1);
    end else if (vtwp_pkg::PAD_W'(cfg_i.words_per_transfer) > vtwp_pkg::PAD_W'(MaxWords)) begin
      wpt_eff = vtwp_pkg::PAD_W'(MaxWords);
    end else begin
      wpt_eff = vtwp_pkg::PAD_W'(cfg_i.words_per_transfer);
    end

    mask  = ~({vtwp_pkg::WORD_W{1'b1}} << w_eff);
    v     = value_i & mask;
    sum   = ({{vtwp_pkg::WORD_W{1'b0}}, v} << held_q) | {{vtwp_pkg::WORD_W{1'b0}}, acc_q};
    tot   = vtwp_pkg::VW_W'(held_q) + w_eff;
    full  = tot[vtwp_pkg::VW_W-1];
    rest  = full ? sum[2*vtwp_pkg::WORD_W-1:vtwp_pkg::WORD_W] : sum[vtwp_pkg::WORD_W-1:0];

    vit_n = vit_q + 9'd1;
    end_t = vtwp_pkg::VCMP_W'(vit_n) >= vpt_eff;
    close = end_t || batch_end_i;
    flush = close && (tot[vtwp_pkg::HELD_W-1:0] != '0);

    wit_a = (full && wit_q != '1) ? wit_q + 5'd1 : wit_q;
    wit_b = (flush && wit_a != '1) ? wit_a + 5'd1 : wit_a;
    wit_x = vtwp_pkg::PAD_W'(wit_b);

    res_o.w0    = sum[vtwp_pkg::WORD_W-1:0];
    res_o.w0_v  = full;
    res_o.w1    = rest;
    res_o.w1_v  = flush;
    res_o.pad   = (end_t && wpt_eff > wit_x) ? wpt_eff - wit_x : '0;
    res_o.batch = batch_end_i;

    if (close) begin
      acc_d  = '0;
      held_d = '0;
      vit_d  = '0;
      wit_d  = '0;
    end else begin
      acc_d  = rest;
      held_d = tot[vtwp_pkg::HELD_W-1:0];
      vit_d  = vit_n;
      wit_d  = wit_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
      vit_q  <= '0;
      wit_q  <= '0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      held_q <= held_d;
      vit_q  <= vit_d;
      wit_q  <= wit_d;
    end
  end

endmodule

[src/vtwp_outbuf.sv]
// Result buffer: holds one value's words, sends one per cycle when ready_i.
module vtwp_outbuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  vtwp_pkg::res_t              res_i,
  output logic                        free_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [vtwp_pkg::WORD_W-1:0] word_o,
  output logic                        run_last_o,
  output logic                        batch_last_o
);

  logic                        w0_v_q, w0_v_d, w1_v_q, w1_v_d, batch_q, batch_d;
  logic [vtwp_pkg::WORD_W-1:0] w0_q, w0_d, w1_q, w1_d;
  logic [vtwp_pkg::PAD_W-1:0]  pad_q, pad_d;
  logic                        last, pop;

  always_comb begin
    valid_o = w0_v_q || w1_v_q || (pad_q != '0);
    if (pad_q == '0) begin
      last = w0_v_q ^ w1_v_q;
    end else begin
      last = !w0_v_q && !w1_v_q && (pad_q == vtwp_pkg::PAD_W'(1));
    end
    pop    = valid_o && ready_i;
    free_o = !valid_o || (pop && last);

    word_o       = w0_v_q ? w0_q : (w1_v_q ? w1_q : '0);
    run_last_o   = last;
    batch_last_o = last && batch_q;

    w0_v_d  = w0_v_q;
    w1_v_d  = w1_v_q;
    pad_d   = pad_q;
    w0_d    = w0_q;
    w1_d    = w1_q;
    batch_d = batch_q;
    if (pop) begin
      if (w0_v_q) begin
        w0_v_d = 1'b0;
      end else if (w1_v_q) begin
        w1_v_d = 1'b0;
      end else begin
        pad_d = pad_q - vtwp_pkg::PAD_W'(1);
      end
    end
    if (load_i) begin
      w0_v_d  = res_i.w0_v;
      w1_v_d  = res_i.w1_v;
      pad_d   = res_i.pad;
      w0_d    = res_i.w0;
      w1_d    = res_i.w1;
      batch_d = res_i.batch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_v_q  <= 1'b0;
      w1_v_q  <= 1'b0;
      pad_q   <= '0;
      batch_q <= 1'b0;
    end else begin
      w0_v_q  <= w0_v_d;
      w1_v_q  <= w1_v_d;
      pad_q   <= pad_d;
      batch_q <= batch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w0_q <= w0_d;
    w1_q <= w1_d;
  end

endmodule
